@@ rtl/core/length_field_frame_splitter_macros.svh @@
// Assertion macros for the length field frame splitter.
// Used by the top level only; no other dependencies.
`ifndef LENGTH_FIELD_FRAME_SPLITTER_MACROS_SVH
`define LENGTH_FIELD_FRAME_SPLITTER_MACROS_SVH
`ifndef SYNTHESIS
`define LFFS_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lffs: same-cycle check failed");
`define LFFS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lffs: next-cycle check failed");
`else
`define LFFS_ASSERT_SAME(lbl, ck, rs, ante, cons)
`define LFFS_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

@@ rtl/core/lffs_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the
// length field frame splitter. No dependencies.
package lffs_pkg;

  localparam int MAX_HEADER = 16;
  localparam int HDR_AW     = $clog2(MAX_HEADER);
  localparam int CFG_DW     = 32;
  localparam int CFG_IW     = 3;
  localparam int LEN_W      = 64;

  localparam logic [CFG_IW-1:0] REG_HEADER_BYTES   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_FIELD_OFFSET   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_FIELD_WIDTH    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MSB_FIRST      = 3'd3;
  localparam logic [CFG_IW-1:0] REG_COUNTS_HEADER  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MAX_FRAME      = 3'd5;

  localparam logic [3:0] FW_TWO   = 4'd2;
  localparam logic [3:0] FW_FOUR  = 4'd4;
  localparam logic [3:0] FW_EIGHT = 4'd8;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_CONFIG = 2'd1,
    ST_WIDTH  = 2'd2,
    ST_FRAME  = 2'd3
  } lffs_status_t;

  typedef struct packed {
    logic         take;
    logic         hdr_write;
    logic         len_start;
    logic         len_run;
    logic         chk;
    logic         hdr_emit;
    logic         hdr_end;
    logic         body_emit;
    logic         err_emit;
    lffs_status_t err_code;
  } lffs_cmd_t;

  typedef struct packed {
    lffs_status_t cfg_code;
    logic         hdr_complete;
    logic         len_done;
    logic         frame_bad;
    logic         hdr_last;
    logic         body_last;
    logic         out_free;
  } lffs_stat_t;

endpackage

@@ rtl/core/lffs_ctrl.sv @@
// Controller for the length field frame splitter: sequences header capture,
// length read, size check and result emission. Depends on lffs_pkg.
module lffs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  lffs_pkg::lffs_stat_t stat,
  output lffs_pkg::lffs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_CHK,
    S_HDR,
    S_BODY,
    S_ERR
  } state_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_ERROR
  } phase_t;

  state_t               state;
  phase_t               phase;
  lffs_pkg::lffs_status_t err_code;
  logic                 accept;
  logic                 cfg_ok;

  assign accept     = byte_valid && (state == S_IDLE);
  assign cfg_ok     = (stat.cfg_code == lffs_pkg::ST_OK);
  assign byte_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.take      = accept;
    cmd.hdr_write = accept && cfg_ok && (phase == PH_HEADER);
    cmd.len_start = cmd.hdr_write && stat.hdr_complete;
    cmd.len_run   = (state == S_LEN);
    cmd.chk       = (state == S_CHK);
    cmd.hdr_emit  = (state == S_HDR) && stat.out_free;
    cmd.hdr_end   = (phase == PH_HEADER);
    cmd.body_emit = (state == S_BODY) && stat.out_free;
    cmd.err_emit  = (state == S_ERR) && stat.out_free;
    cmd.err_code  = err_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_HEADER;
      err_code <= lffs_pkg::ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!cfg_ok) begin
              err_code <= stat.cfg_code;
              state    <= S_ERR;
            end else if (phase == PH_ERROR) begin
              err_code <= lffs_pkg::ST_FRAME;
              state    <= S_ERR;
            end else if (phase == PH_BODY) begin
              state <= S_BODY;
            end else if (stat.hdr_complete) begin
              state <= S_LEN;
            end
          end
        end
        S_LEN: begin
          if (stat.len_done) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (stat.frame_bad) begin
            phase    <= PH_ERROR;
            err_code <= lffs_pkg::ST_FRAME;
            state    <= S_ERR;
          end else begin
            state <= S_HDR;
            if (stat.body_last && !stat.frame_bad) begin
              phase <= PH_BODY;
            end
          end
        end
        S_HDR: begin
          if (stat.out_free && stat.hdr_last) begin
            state <= S_IDLE;
          end
        end
        S_BODY: begin
          if (stat.out_free) begin
            state <= S_IDLE;
            if (stat.body_last) begin
              phase <= PH_HEADER;
            end
          end
        end
        S_ERR: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/lffs_dp.sv @@
// Datapath for the length field frame splitter: configuration registers,
// header store, length assembly, size check and the result register.
// Depends on lffs_pkg.
module lffs_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lffs_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [lffs_pkg::CFG_DW-1:0]      cfg_data,
  input  logic [7:0]                       data_byte,
  input  lffs_pkg::lffs_cmd_t              cmd,
  output lffs_pkg::lffs_stat_t             stat,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [7:0]                       out_byte,
  output logic                             frame_start,
  output logic                             frame_end,
  output logic                             run_last,
  output lffs_pkg::lffs_status_t           status
);

  logic [4:0]  header_bytes;
  logic [3:0]  field_offset;
  logic [3:0]  field_width;
  logic        msb_first;
  logic        length_counts_header;
  logic [31:0] max_frame_bytes;

  logic [7:0]  hdr_mem [lffs_pkg::MAX_HEADER];
  logic [7:0]  rd_q;
  logic        rd_en;
  logic [lffs_pkg::HDR_AW-1:0] rd_addr;

  logic [4:0]  header_count;
  logic [4:0]  hc_eff;
  logic [4:0]  hc_inc;
  logic [7:0]  data_q;

  logic [3:0]  len_idx;
  logic        len_pend;
  logic [lffs_pkg::LEN_W-1:0] len_acc;
  logic [3:0]  len_sel;
  logic        len_more;

  logic [31:0] hb32;
  logic [31:0] len_lo;
  logic [31:0] limit;
  logic [31:0] body;
  logic [31:0] body_remaining;
  logic [4:0]  off_end;
  logic [lffs_pkg::HDR_AW-1:0] emit_idx;

  lffs_pkg::lffs_status_t cfg_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes         <= 5'd4;
      field_offset         <= 4'd0;
      field_width          <= lffs_pkg::FW_FOUR;
      msb_first            <= 1'b1;
      length_counts_header <= 1'b0;
      max_frame_bytes      <= 32'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lffs_pkg::REG_HEADER_BYTES:  header_bytes         <= cfg_data[4:0];
        lffs_pkg::REG_FIELD_OFFSET:  field_offset         <= cfg_data[3:0];
        lffs_pkg::REG_FIELD_WIDTH:   field_width          <= cfg_data[3:0];
        lffs_pkg::REG_MSB_FIRST:     msb_first            <= cfg_data[0];
        lffs_pkg::REG_COUNTS_HEADER: length_counts_header <= cfg_data[0];
        lffs_pkg::REG_MAX_FRAME:     max_frame_bytes      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign hb32    = 32'(header_bytes);
  assign off_end = {1'b0, field_offset} + {1'b0, field_width};

  always_comb begin
    if (header_bytes == 5'd0 || header_bytes > 5'(lffs_pkg::MAX_HEADER)) begin
      cfg_code = lffs_pkg::ST_CONFIG;
    end else if (field_width != lffs_pkg::FW_TWO && field_width != lffs_pkg::FW_FOUR &&
                 field_width != lffs_pkg::FW_EIGHT) begin
      cfg_code = lffs_pkg::ST_WIDTH;
    end else if (off_end > header_bytes) begin
      cfg_code = lffs_pkg::ST_CONFIG;
    end else if (max_frame_bytes < hb32) begin
      cfg_code = lffs_pkg::ST_CONFIG;
    end else begin
      cfg_code = lffs_pkg::ST_OK;
    end
  end

  // header capture
  assign hc_eff = (header_count >= header_bytes) ? 5'd0 : header_count;
  assign hc_inc = hc_eff + 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= 5'd0;
    end else if (cmd.hdr_write) begin
      header_count <= hc_inc;
    end else if ((cmd.chk && !stat.frame_bad) || (cmd.body_emit && stat.body_last)) begin
      header_count <= 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      data_q <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_write) begin
      hdr_mem[hc_eff[lffs_pkg::HDR_AW-1:0]] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= hdr_mem[rd_addr];
    end
  end

  // length assembly: little endian fields are walked from the top byte down
  assign len_more = (len_idx < field_width);
  assign len_sel  = msb_first ? len_idx : (field_width - 4'd1 - len_idx);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.len_run && len_more) begin
      rd_en   = 1'b1;
      rd_addr = lffs_pkg::HDR_AW'(field_offset + len_sel);
    end else if (cmd.chk) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.hdr_emit) begin
      rd_en   = 1'b1;
      rd_addr = emit_idx + lffs_pkg::HDR_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_idx  <= 4'd0;
      len_pend <= 1'b0;
    end else if (cmd.len_start) begin
      len_idx  <= 4'd0;
      len_pend <= 1'b0;
    end else if (cmd.len_run) begin
      len_pend <= len_more;
      if (len_more) begin
        len_idx <= len_idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_start) begin
      len_acc <= '0;
    end else if (cmd.len_run && len_pend) begin
      len_acc <= {len_acc[lffs_pkg::LEN_W-9:0], rd_q};
    end
  end

  // frame size check
  assign len_lo = len_acc[31:0];
  assign limit  = length_counts_header ? max_frame_bytes : (max_frame_bytes - hb32);
  assign body   = length_counts_header ? (len_lo - hb32) : len_lo;

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      body_remaining <= body;
    end else if (cmd.body_emit) begin
      body_remaining <= stat.body_last ? 32'd0 : (body_remaining - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      emit_idx <= '0;
    end else if (cmd.hdr_emit) begin
      emit_idx <= emit_idx + lffs_pkg::HDR_AW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.hdr_emit || cmd.body_emit || cmd.err_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_emit) begin
      out_byte    <= rd_q;
      frame_start <= (emit_idx == '0);
      frame_end   <= stat.hdr_last && cmd.hdr_end;
      run_last    <= stat.hdr_last;
      status      <= lffs_pkg::ST_OK;
    end else if (cmd.body_emit) begin
      out_byte    <= data_q;
      frame_start <= 1'b0;
      frame_end   <= stat.body_last;
      run_last    <= 1'b1;
      status      <= lffs_pkg::ST_OK;
    end else if (cmd.err_emit) begin
      out_byte    <= 8'd0;
      frame_start <= 1'b0;
      frame_end   <= 1'b0;
      run_last    <= 1'b1;
      status      <= cmd.err_code;
    end
  end

  always_comb begin
    stat.cfg_code     = cfg_code;
    stat.hdr_complete = (hc_inc == header_bytes);
    stat.len_done     = !len_more && !len_pend;
    stat.frame_bad    = (|len_acc[lffs_pkg::LEN_W-1:32]) || (len_lo > limit) ||
                        (length_counts_header && (len_lo < hb32));
    stat.hdr_last     = ((5'(emit_idx) + 5'd1) == header_bytes);
    // in the check cycle this flags a non-empty body for the controller
    stat.body_last    = cmd.chk ? (body != 32'd0) : (body_remaining <= 32'd1);
    stat.out_free     = !result_valid || !result_stall;
  end

endmodule

@@ rtl/core/length_field_frame_splitter.sv @@
// Top level of the length field frame splitter: joins controller and
// datapath. Depends on lffs_pkg, lffs_ctrl, lffs_dp and the macro header.
//
//  channel  handshake                    payload
//  byte     byte_valid / byte_stall      data_byte
//  result   result_valid / result_stall  out_byte, frame_start, frame_end, run_last, status
//  config   cfg_write                    cfg_index, cfg_data
//
// A byte that leaves the header incomplete is only stored; body and error bytes then pass
// through an emit state. The byte that completes a header starts the length read (one read
// per length byte), assembly and check, and then the header emission byte by byte on the
// single read port of the header store. Synchronous reset restores register defaults.
// A stalled result register holds the controller in place; a byte may still be taken
// while the last result of the previous byte waits there.
`include "length_field_frame_splitter_macros.svh"
module length_field_frame_splitter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lffs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [lffs_pkg::CFG_DW-1:0] cfg_data,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  logic [7:0]                  data_byte,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [7:0]                  out_byte,
  output logic                        frame_start,
  output logic                        frame_end,
  output logic                        run_last,
  output logic [1:0]                  status
);

  lffs_pkg::lffs_cmd_t    cmd;
  lffs_pkg::lffs_stat_t   stat;
  lffs_pkg::lffs_status_t status_q;
  logic [2:0]             emit_vec;
  logic                   cfg_bad_take;
  logic                   bad_payload;

  lffs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  lffs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .frame_start  (frame_start),
    .frame_end    (frame_end),
    .run_last     (run_last),
    .status       (status_q)
  );

  assign status = status_q;

  assign emit_vec     = {cmd.hdr_emit, cmd.body_emit, cmd.err_emit};
  assign cfg_bad_take = cmd.take && (stat.cfg_code != lffs_pkg::ST_OK);
  assign bad_payload  = (out_byte != 8'd0) || frame_start || frame_end || !run_last;

  `LFFS_ASSERT_SAME(a_one_load, clk, rst, 1'b1, $onehot0(emit_vec))
  `LFFS_ASSERT_SAME(a_err_clean, clk, rst, result_valid && (status_q != lffs_pkg::ST_OK), !bad_payload)
  `LFFS_ASSERT_SAME(a_start_ok, clk, rst, result_valid && frame_start, status_q == lffs_pkg::ST_OK)
  `LFFS_ASSERT_NEXT(a_cfg_err_busy, clk, rst, cfg_bad_take, byte_stall)

endmodule
